>>> rtl/core/qypr_pkg.sv
package qypr_pkg;

  localparam int AngleBits = 16;
  localparam int TabLen    = 24;
  localparam int NumIter   = (AngleBits > TabLen) ? TabLen : AngleBits;
  // Products are below 2^31 in magnitude; the vector sums reach 2^32.
  // CORDIC growth stays below 2^36, so 38 bits hold every operand.
  localparam int CW        = 38;
  localparam int GainQ24   = 27628053;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
  } euler_t;

  // One CORDIC lane in flight.
  typedef struct packed {
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] v;
    logic [31:0]          acc;
  } lane_t;

  function automatic logic [31:0] atan_tab(input int i);
    logic [31:0] t;
    unique case (i)
      0:  t = 32'h20000000;  1:  t = 32'h12E4051E;
      2:  t = 32'h09FB385B;  3:  t = 32'h051111D4;
      4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;
      8:  t = 32'h0028BE53;  9:  t = 32'h00145F2F;
      10: t = 32'h000A2F98;  11: t = 32'h000517CC;
      12: t = 32'h00028BE6;  13: t = 32'h000145F3;
      14: t = 32'h0000A2FA;  15: t = 32'h0000517D;
      16: t = 32'h000028BE;  17: t = 32'h0000145F;
      18: t = 32'h00000A30;  19: t = 32'h00000518;
      20: t = 32'h0000028C;  21: t = 32'h00000146;
      22: t = 32'h000000A3;  23: t = 32'h00000051;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

  // Half-plane fold ahead of the micro-rotations.
  function automatic lane_t lane_init(input logic signed [CW-1:0] y,
                                      input logic signed [CW-1:0] v);
    lane_t l;
    l.y = y;
    l.v = v;
    l.acc = 32'h0;
    if (v < 0) begin
      l.y = -y;
      l.v = -v;
      l.acc = 32'h80000000;
    end
    return l;
  endfunction

  function automatic lane_t lane_rot(input lane_t l, input int i);
    lane_t r;
    r = l;
    if (l.y >= 0) begin
      r.v = l.v + (l.y >>> i);
      r.y = l.y - (l.v >>> i);
      r.acc = l.acc + atan_tab(i);
    end else begin
      r.v = l.v - (l.y >>> i);
      r.y = l.y + (l.v >>> i);
      r.acc = l.acc - atan_tab(i);
    end
    return r;
  endfunction

  function automatic logic [15:0] to_out(input logic [31:0] a);
    logic [31:0] s;
    s = a + 32'h8000;
    return s[31:16];
  endfunction

endpackage

>>> rtl/core/qypr_front.sv
// Products, then vector sums; two register stages.
module qypr_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  qypr_pkg::quat_t                quat_i,
  output logic                           valid_o,
  output logic signed [qypr_pkg::CW-1:0] gx_o,
  output logic signed [qypr_pkg::CW-1:0] gy_o,
  output logic signed [qypr_pkg::CW-1:0] gz_o,
  output logic signed [qypr_pkg::CW-1:0] yn_o,
  output logic signed [qypr_pkg::CW-1:0] yd_o
);
  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, xz_q, wy_q, wx_q, yz_q, xy_q, wz_q;
  logic v1_q, v2_q;
  logic signed [qypr_pkg::CW-1:0] gx_q, gy_q, gz_q, yn_q, yd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ww_q <= quat_i.quat_w * quat_i.quat_w;
    xx_q <= quat_i.quat_x * quat_i.quat_x;
    yy_q <= quat_i.quat_y * quat_i.quat_y;
    zz_q <= quat_i.quat_z * quat_i.quat_z;
    xz_q <= quat_i.quat_x * quat_i.quat_z;
    wy_q <= quat_i.quat_w * quat_i.quat_y;
    wx_q <= quat_i.quat_w * quat_i.quat_x;
    yz_q <= quat_i.quat_y * quat_i.quat_z;
    xy_q <= quat_i.quat_x * quat_i.quat_y;
    wz_q <= quat_i.quat_w * quat_i.quat_z;
    gx_q <= (qypr_pkg::CW'(xz_q) - qypr_pkg::CW'(wy_q)) <<< 1;
    gy_q <= (qypr_pkg::CW'(wx_q) + qypr_pkg::CW'(yz_q)) <<< 1;
    gz_q <= qypr_pkg::CW'(ww_q) - qypr_pkg::CW'(xx_q) - qypr_pkg::CW'(yy_q)
            + qypr_pkg::CW'(zz_q);
    yn_q <= (qypr_pkg::CW'(xy_q) - qypr_pkg::CW'(wz_q)) <<< 1;
    yd_q <= ((qypr_pkg::CW'(ww_q) + qypr_pkg::CW'(xx_q)) <<< 1)
            - (qypr_pkg::CW'(1) <<< 28);
  end

  assign valid_o = v2_q;
  assign gx_o = gx_q;
  assign gy_o = gy_q;
  assign gz_o = gz_q;
  assign yn_o = yn_q;
  assign yd_o = yd_q;
endmodule

>>> rtl/core/qypr_cordic.sv
// Pipelined vectoring CORDIC, one micro-rotation per stage.
// Zero input gives zero angle and length.
module qypr_cordic (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [qypr_pkg::CW-1:0] y_i,
  input  logic signed [qypr_pkg::CW-1:0] v_i,
  output logic                           valid_o,
  output logic [31:0]                    angle_o,
  output logic signed [qypr_pkg::CW-1:0] mag_o
);
  localparam int N = qypr_pkg::NumIter;

  qypr_pkg::lane_t lane_q [N+1];
  logic [N:0] vld_q;
  logic [N:0] zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[N-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q[0] <= qypr_pkg::lane_init(y_i, v_i);
    zero_q <= {zero_q[N-1:0], (y_i == '0) && (v_i == '0)};
    for (int i = 0; i < N; i++) begin
      lane_q[i+1] <= qypr_pkg::lane_rot(lane_q[i], i);
    end
  end

  assign valid_o = vld_q[N];
  assign angle_o = zero_q[N] ? 32'h0 : lane_q[N].acc;
  assign mag_o   = zero_q[N] ? '0 : lane_q[N].v;
endmodule

>>> rtl/core/quaternion_to_yaw_pitch_roll.sv
// Channel | dir | handshake       | payload
// quat    | in  | start, busy     | quat_i  (qypr_pkg::quat_t)
// euler   | out | done_o strobe   | euler_o (qypr_pkg::euler_t)
// One quaternion per cycle; busy is always low.
// Path: two product/sum stages, the roll and yaw CORDIC pipelines,
// a gain multiply stage, the pitch CORDIC, output reg.
// Reset clears only the valid bits; the receiver cannot stall.
module quaternion_to_yaw_pitch_roll (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  qypr_pkg::quat_t  quat_i,
  output logic             done_o,
  output qypr_pkg::euler_t euler_o
);
  localparam int N  = qypr_pkg::NumIter;
  localparam int CW = qypr_pkg::CW;

  logic fv;
  logic signed [CW-1:0] gx, gy, gz, yn, yd;
  logic rv, yv, pv;
  logic [31:0] ra, ya, pa;
  logic signed [CW-1:0] mag, yunused;

  assign busy = 1'b0;

  qypr_front u_front (
    .clk_i, .rst_ni, .valid_i(start), .quat_i, .valid_o(fv),
    .gx_o(gx), .gy_o(gy), .gz_o(gz), .yn_o(yn), .yd_o(yd)
  );

  qypr_cordic u_roll (
    .clk_i, .rst_ni, .valid_i(fv), .y_i(gy), .v_i(gz),
    .valid_o(rv), .angle_o(ra), .mag_o(mag)
  );

  qypr_cordic u_yaw (
    .clk_i, .rst_ni, .valid_i(fv), .y_i(yn), .v_i(yd),
    .valid_o(yv), .angle_o(ya), .mag_o(yunused)
  );

  // gx and the sign of gz ride alongside the roll CORDIC.
  logic signed [CW-1:0] gx_dly_q [N+1];
  logic [N:0] neg_dly_q;
  always_ff @(posedge clk_i) begin
    gx_dly_q[0] <= gx;
    neg_dly_q[0] <= gz < 0;
    for (int i = 0; i < N; i++) begin
      gx_dly_q[i+1] <= gx_dly_q[i];
      neg_dly_q[i+1] <= neg_dly_q[i];
    end
  end

  // Gain multiply stage, rounded back to the CORDIC width.
  logic signed [CW+25:0] gxk_full;
  logic signed [CW-1:0] gxk_q, mag_q;
  logic [31:0] ra_q, ya_q;
  logic neg_q, gv_q;
  assign gxk_full = gx_dly_q[N] * $signed(26'(qypr_pkg::GainQ24))
                    + (64'sd1 <<< 23);
  always_ff @(posedge clk_i) begin
    gxk_q <= CW'(gxk_full >>> 24);
    mag_q <= mag;
    ra_q  <= ra;
    ya_q  <= ya;
    neg_q <= neg_dly_q[N];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gv_q <= 1'b0;
    else gv_q <= rv;
  end

  qypr_cordic u_pitch (
    .clk_i, .rst_ni, .valid_i(gv_q), .y_i(gxk_q), .v_i(mag_q),
    .valid_o(pv), .angle_o(pa), .mag_o()
  );

  logic [31:0] ra_dly_q [N+1];
  logic [31:0] ya_dly_q [N+1];
  logic [N:0] negp_q;
  always_ff @(posedge clk_i) begin
    ra_dly_q[0] <= ra_q;
    ya_dly_q[0] <= ya_q;
    negp_q[0] <= neg_q;
    for (int i = 0; i < N; i++) begin
      ra_dly_q[i+1] <= ra_dly_q[i];
      ya_dly_q[i+1] <= ya_dly_q[i];
      negp_q[i+1] <= negp_q[i];
    end
  end

  logic [31:0] pf;
  assign pf = negp_q[N] ? (32'h80000000 - pa) : pa;

  logic done_q;
  qypr_pkg::euler_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= pv;
  end
  always_ff @(posedge clk_i) begin
    out_q.yaw_angle   <= qypr_pkg::to_out(ya_dly_q[N]);
    out_q.pitch_angle <= qypr_pkg::to_out(pf);
    out_q.roll_angle  <= qypr_pkg::to_out(ra_dly_q[N]);
  end

  assign done_o = done_q;
  assign euler_o = out_q;

  logic unused_ok;
  assign unused_ok = yv ^ (^yunused);
endmodule

>>> rtl/core/qypr_checker.sv
module qypr_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input qypr_pkg::quat_t  quat_i,
  input logic             done_o,
  input qypr_pkg::euler_t euler_o
);
  localparam int Lat = 2 * qypr_pkg::NumIter + 6;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat done_o) else $error("result missing");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, Lat)) else $error("unexpected result");
  // zero quaternion: yaw denominator is -1, so yaw lands on pi
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && quat_i == '0) |-> ##Lat (euler_o.yaw_angle == 16'sh8000 &&
    euler_o.pitch_angle == '0 && euler_o.roll_angle == '0))
    else $error("zero quaternion gives wrong angles");
endmodule

bind quaternion_to_yaw_pitch_roll qypr_checker u_qypr_checker (.*);

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int LATENCY   = 2 * qypr_pkg::NumIter + 6;
  localparam int WDOG_MAX  = 20 * LATENCY + 2000;
  localparam int RAND_ITEMS = 1530;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  qypr_pkg::quat_t   quat_i = '0;
  logic    done;
  qypr_pkg::euler_t  euler_o;

  quaternion_to_yaw_pitch_roll u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .quat_i (quat_i),
    .done_o (done),
    .euler_o(euler_o)
  );

  always #10 clk_i = ~clk_i;

  qypr_pkg::euler_t angles_q[$];
  int     n_err = 0;
  int     n_in = 0;
  int     n_out = 0;
  int     idle_cnt = 0;
  int     send_idle_pct = 11;

  // Table entries: unpacked 32-bit angle table, same values as qypr_pkg::atan_tab.
  logic [31:0] tab [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

  function automatic logic [31:0] vec_angle(input longint yy, input longint vv,
                                            output longint mag);
    logic [31:0] acc;
    longint dv, dy;
    acc = '0;
    mag = 0;
    if (yy == 0 && vv == 0) return 32'h0;
    if (vv < 0) begin
      vv = -vv;
      yy = -yy;
      acc = 32'h80000000;
    end
    for (int i = 0; i < qypr_pkg::NumIter; i++) begin
      dv = yy >>> i;
      dy = vv >>> i;
      if (yy >= 0) begin
        vv += dv;
        yy -= dy;
        acc += tab[i];
      end else begin
        vv -= dv;
        yy += dy;
        acc -= tab[i];
      end
    end
    mag = vv;
    return acc;
  endfunction

  function automatic logic [15:0] round_angle(input logic [31:0] a);
    logic [31:0] s;
    s = a + 32'h8000;
    return s[31:16];
  endfunction

  function automatic qypr_pkg::euler_t attitude_of(input qypr_pkg::quat_t q);
    longint w, x, y, z, gx, gy, gz, ynum, yden, mag, scratch, gxk;
    logic [31:0] yaw, pitch, roll;
    qypr_pkg::euler_t e;
    w = q.quat_w;
    x = q.quat_x;
    y = q.quat_y;
    z = q.quat_z;
    gx = 2 * (x * z - w * y);
    gy = 2 * (w * x + y * z);
    gz = w * w - x * x - y * y + z * z;
    ynum = 2 * (x * y - w * z);
    yden = 2 * (w * w + x * x) - (64'sd1 <<< 28);
    yaw = vec_angle(ynum, yden, scratch);
    roll = vec_angle(gy, gz, mag);
    gxk = (gx * qypr_pkg::GainQ24 + (64'sd1 <<< 23)) >>> 24;
    pitch = vec_angle(gxk, mag, scratch);
    if (gz < 0) pitch = 32'h80000000 - pitch;
    e.yaw_angle = round_angle(yaw);
    e.pitch_angle = round_angle(pitch);
    e.roll_angle = round_angle(roll);
    return e;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_err++;
    $display("mismatch result %0d %s: got %0d want %0d", n_out, what, got, want);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done) begin
      qypr_pkg::euler_t want;
      if (angles_q.size() == 0) begin
        n_err++;
        $display("unexpected result %0d", n_out);
      end else begin
        want = angles_q.pop_front();
        if (euler_o.yaw_angle !== want.yaw_angle)
          report_mismatch("yaw", euler_o.yaw_angle, want.yaw_angle);
        if (euler_o.pitch_angle !== want.pitch_angle)
          report_mismatch("pitch", euler_o.pitch_angle, want.pitch_angle);
        if (euler_o.roll_angle !== want.roll_angle)
          report_mismatch("roll", euler_o.roll_angle, want.roll_angle);
      end
      n_out++;
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || done) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WDOG_MAX) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_quat(input qypr_pkg::quat_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    quat_i <= q;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    angles_q.push_back(attitude_of(q));
    n_in++;
    @(negedge clk_i);
  endtask

  typedef struct {
    qypr_pkg::quat_t  q;
    logic             known;
    qypr_pkg::euler_t want;
  } quat_row_t;

  function automatic logic [15:0] rand_comp(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(32767, 32700));
      2: return 16'(-$urandom_range(32768, 32700));
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  initial begin
    quat_row_t rows[$];
    qypr_pkg::quat_t q;
    int mode;
    rows = '{
      // zero quaternion: yaw denominator is -1, so yaw sits at pi
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sh8000, 16'sd0, 16'sd0}},
      // identity: every angle is zero
      '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 16'sd0}},
      '{'{16'sd0, 16'sd16384, 16'sd0, 16'sd0}, 1'b0, '0},
      '{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 1'b0, '0},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, '0},
      '{'{-16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
      '{'{16'sd11585, 16'sd11585, 16'sd0, 16'sd0}, 1'b0, '0},
      '{'{16'sd11585, 16'sd0, 16'sd11585, 16'sd0}, 1'b0, '0},
      '{'{16'sd11585, 16'sd0, -16'sd11585, 16'sd0}, 1'b0, '0},
      '{'{16'sd11585, 16'sd0, 16'sd0, 16'sd11585}, 1'b0, '0},
      '{'{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192}, 1'b0, '0},
      '{'{-16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192}, 1'b0, '0},
      // gz < 0 fold, with gx zero and gx positive
      '{'{16'sd2000, 16'sd14000, 16'sd7000, 16'sd1000}, 1'b0, '0},
      '{'{16'sd2000, 16'sd14000, -16'sd7000, 16'sd1000}, 1'b0, '0},
      // non-unit extremes
      '{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, '0},
      '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0},
      '{'{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff}, 1'b0, '0},
      '{'{16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
      '{'{16'sd0, -16'sd1, 16'sd0, 16'sd0}, 1'b0, '0},
      '{'{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa}, 1'b0, '0}
    };
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[k]) begin
      if (rows[k].known && attitude_of(rows[k].q) != rows[k].want) begin
        n_err++;
        $display("directed row %0d: typed value disagrees with prediction", k);
      end
      send_quat(rows[k].q);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) send_idle_pct = 75;
      if (n == 2 * RAND_ITEMS / 3) send_idle_pct = 0;
      if (n == RAND_ITEMS / 2) begin
        // hold off until the pipeline has drained
        start <= 1'b0;
        while (angles_q.size() != 0) @(negedge clk_i);
      end
      mode = $urandom_range(9);
      q.quat_w = rand_comp(mode < 2 ? 0 : mode % 4);
      q.quat_x = rand_comp(mode < 2 ? 0 : (mode + 1) % 4);
      q.quat_y = rand_comp(mode < 2 ? 0 : (mode + 2) % 4);
      q.quat_z = rand_comp(mode < 2 ? 0 : 3);
      send_quat(q);
    end
    start <= 1'b0;

    while (angles_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);

    $display("%0d quaternions sent, %0d attitude results checked", n_in, n_out);
    $display("covered: zero and axis quaternions, pi wrap, pitch fold, full-scale inputs");
    if (n_err == 0 && angles_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
